// ===== hw/rtl/rlgr_pkg.sv =====
// Shared types, constants and helper functions for the RLGR entropy decoder.
`timescale 1ns / 1ps
package rlgr_pkg;

    localparam int MAX_OUTPUT_LENGTH_DEF = 4096;
    localparam int LEN_W                 = 13;
    localparam int COEF_W                = 16;
    localparam int KP_W                  = 7;
    localparam logic [KP_W-1:0] KP_LIMIT = 7'd80;
    localparam logic [KP_W-1:0] KP_RESET = 7'd8;
    localparam int GR_SHIFT              = 3;
    localparam logic [7:0] RL_UP         = 8'd4;
    localparam logic [KP_W-1:0] RL_DOWN  = 7'd6;
    localparam logic [7:0] GR_UP         = 8'd3;
    localparam logic [KP_W-1:0] GR_DOWN  = 7'd3;
    localparam logic [LEN_W-1:0] OUT_LEN_RESET = 13'd4096;

    // Configuration register indexes
    localparam logic [7:0] REG_MODE    = 8'd0;
    localparam logic [7:0] REG_OUT_LEN = 8'd1;

    typedef enum logic [3:0] {
        PH_START,
        PH_ZEROS,
        PH_RUNREM,
        PH_SIGN,
        PH_ONES,
        PH_RICE,
        PH_SPLIT,
        PH_SPLIT2,
        PH_FULL
    } phase_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_BITS,
        TS_CLOSE
    } top_state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_BIT,
        CMD_CLOSE
    } step_cmd_t;

    typedef struct packed {
        step_cmd_t cmd;
        logic      bit_in;
    } step_req_t;

    typedef struct packed {
        logic                     res_valid;
        logic [LEN_W-1:0]         zero_run;
        logic signed [COEF_W-1:0] coefficient;
        logic                     has_coefficient;
        logic                     last;
        logic                     bit_done;
        logic                     pending;
    } step_rsp_t;

    // Saturating raise of an adaptation parameter
    function automatic logic [KP_W-1:0] kp_add(input logic [KP_W-1:0] kp,
                                               input logic [7:0] d);
        logic [8:0] sum;
        sum = {2'b00, kp} + {1'b0, d};
        return (sum > {2'b00, KP_LIMIT}) ? KP_LIMIT : sum[KP_W-1:0];
    endfunction

    // Lower an adaptation parameter, floor at zero
    function automatic logic [KP_W-1:0] kp_sub(input logic [KP_W-1:0] kp,
                                               input logic [KP_W-1:0] d);
        return (kp > d) ? kp - d : '0;
    endfunction

    // Map an interleaved code back to a signed value, 17-bit wrap
    function automatic logic [COEF_W-1:0] half_mag(input logic [COEF_W:0] v);
        logic [COEF_W:0] t;
        t = v + 17'd1;
        return v[0] ? (16'd0 - t[COEF_W:1]) : v[COEF_W:1];
    endfunction

    // Bit length of a 16-bit code
    function automatic logic [4:0] bit_len(input logic [COEF_W-1:0] c);
        logic [4:0] nb;
        nb = '0;
        for (int i = 0; i < COEF_W; i++) begin
            if (c[i]) nb = 5'(i + 1);
        end
        return nb;
    endfunction

endpackage

// ===== hw/rtl/rlgr_core.sv =====
// Bit-serial RLGR decode unit: one stream bit or one emission per step.
`timescale 1ns / 1ps
module rlgr_core #(
    parameter int MAX_OUTPUT_LENGTH = rlgr_pkg::MAX_OUTPUT_LENGTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rlgr_pkg::step_req_t         req,
    input  logic                        mode,
    input  logic [rlgr_pkg::LEN_W-1:0]  out_len,
    output rlgr_pkg::step_rsp_t         rsp
);
    import rlgr_pkg::*;

    localparam int RUN_W = $clog2(MAX_OUTPUT_LENGTH + 1);

    phase_t             phase_reg, phase_next;
    logic [KP_W-1:0]    kp_reg, kp_next;
    logic [KP_W-1:0]    krp_reg, krp_next;
    logic [COEF_W-1:0]  buf_reg, buf_next;
    logic [4:0]         held_reg, held_next;
    logic [COEF_W-1:0]  unary_reg, unary_next;
    logic [7:0]         usat_reg, usat_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [COEF_W-1:0]  code_reg, code_next;
    logic               sign_reg, sign_next;
    logic [LEN_W-1:0]   emitted_reg, emitted_next;
    logic               from_run_reg, from_run_next;

    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   room0;
    logic [LEN_W-1:0]   room1;
    logic [LEN_W-1:0]   zr;
    logic [3:0]         kr;
    logic [COEF_W-1:0]  code;
    logic [COEF_W-1:0]  v1;
    logic [COEF_W:0]    v2;
    logic [4:0]         nbits;
    logic [31:0]        run_sum;
    logic               do_rice;
    logic               do_split;
    phase_t             ph;

    // Clamp the configured length to the supported maximum
    assign eff_len = (32'(out_len) > 32'(MAX_OUTPUT_LENGTH))
                   ? LEN_W'(MAX_OUTPUT_LENGTH) : out_len;
    assign room0   = (emitted_reg < eff_len) ? eff_len - emitted_reg : '0;

    // Decode one step
    always_comb begin
        phase_next    = phase_reg;
        kp_next       = kp_reg;
        krp_next      = krp_reg;
        buf_next      = buf_reg;
        held_next     = held_reg;
        unary_next    = unary_reg;
        usat_next     = usat_reg;
        run_next      = run_reg;
        code_next     = code_reg;
        sign_next     = sign_reg;
        emitted_next  = emitted_reg;
        from_run_next = from_run_reg;
        rsp           = '0;
        rsp.pending   = (phase_reg == PH_SPLIT2);
        room1         = '0;
        zr            = '0;
        kr            = krp_reg[6:3];
        code          = '0;
        v1            = '0;
        v2            = '0;
        nbits         = '0;
        run_sum       = '0;
        do_rice       = 1'b0;
        do_split      = 1'b0;
        ph            = phase_reg;

        case (req.cmd)
            CMD_CLOSE: begin
                rsp.res_valid = 1'b1;
                rsp.zero_run  = room0;
                rsp.last      = 1'b1;
                phase_next    = PH_START;
                kp_next       = KP_RESET;
                krp_next      = KP_RESET;
                buf_next      = '0;
                held_next     = '0;
                unary_next    = '0;
                usat_next     = '0;
                run_next      = '0;
                code_next     = '0;
                sign_next     = 1'b0;
                emitted_next  = '0;
                from_run_next = 1'b0;
            end
            CMD_BIT: begin
                if (phase_reg == PH_SPLIT2) begin
                    // Second value of a split code, no bit consumed
                    if (room0 != '0) begin
                        emitted_next        = emitted_reg + 1'b1;
                        rsp.res_valid       = 1'b1;
                        rsp.coefficient     = code_reg;
                        rsp.has_coefficient = 1'b1;
                    end
                    phase_next = PH_START;
                end else begin
                    rsp.bit_done = 1'b1;
                    // Open a new code, or mark the block full
                    if (ph == PH_START) begin
                        if (room0 == '0) begin
                            ph = PH_FULL;
                        end else begin
                            run_next      = '0;
                            unary_next    = '0;
                            usat_next     = '0;
                            buf_next      = '0;
                            held_next     = '0;
                            sign_next     = 1'b0;
                            code_next     = '0;
                            from_run_next = (kp_reg[6:3] != 4'd0);
                            ph = (kp_reg[6:3] != 4'd0) ? PH_ZEROS : PH_ONES;
                        end
                        phase_next = ph;
                    end
                    case (ph)
                        PH_ZEROS: begin
                            if (!req.bit_in) begin
                                run_sum  = 32'(run_next) + (32'd1 << kp_next[6:3]);
                                run_next = (run_sum > 32'(MAX_OUTPUT_LENGTH))
                                         ? RUN_W'(MAX_OUTPUT_LENGTH) : RUN_W'(run_sum);
                                kp_next  = kp_add(kp_next, RL_UP);
                            end else if (kp_next[6:3] != 4'd0) begin
                                held_next  = {1'b0, kp_next[6:3]};
                                buf_next   = '0;
                                phase_next = PH_RUNREM;
                            end else begin
                                phase_next = PH_SIGN;
                            end
                        end
                        PH_RUNREM: begin
                            buf_next  = {buf_next[COEF_W-2:0], req.bit_in};
                            held_next = held_next - 1'b1;
                            if (held_next == '0) begin
                                run_sum  = 32'(run_next) + 32'(buf_next);
                                run_next = (run_sum > 32'(MAX_OUTPUT_LENGTH))
                                         ? RUN_W'(MAX_OUTPUT_LENGTH) : RUN_W'(run_sum);
                                phase_next = PH_SIGN;
                            end
                        end
                        PH_SIGN: begin
                            sign_next  = req.bit_in;
                            phase_next = PH_ONES;
                        end
                        PH_ONES: begin
                            if (req.bit_in) begin
                                unary_next = unary_next + 1'b1;
                                if (usat_next != 8'hFF) usat_next = usat_next + 1'b1;
                            end else if (kr != 4'd0) begin
                                held_next  = {1'b0, kr};
                                buf_next   = '0;
                                phase_next = PH_RICE;
                            end else begin
                                buf_next = '0;
                                do_rice  = 1'b1;
                            end
                        end
                        PH_RICE: begin
                            buf_next  = {buf_next[COEF_W-2:0], req.bit_in};
                            held_next = held_next - 1'b1;
                            if (held_next == '0) do_rice = 1'b1;
                        end
                        PH_SPLIT: begin
                            buf_next  = {buf_next[COEF_W-2:0], req.bit_in};
                            held_next = held_next - 1'b1;
                            if (held_next == '0) begin
                                do_split = 1'b1;
                                v1       = buf_next;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // Close a Golomb-Rice code
                    if (do_rice) begin
                        code = buf_next | COEF_W'(unary_next << kr);
                        if (usat_next == 8'd0) begin
                            krp_next = kp_sub(krp_next, 7'd2);
                        end else if (usat_next != 8'd1) begin
                            krp_next = kp_add(krp_next, usat_next);
                        end
                        phase_next = PH_START;
                        if (from_run_next) begin
                            kp_next = kp_sub(kp_next, RL_DOWN);
                            zr = (32'(run_next) < 32'(room0)) ? LEN_W'(run_next) : room0;
                            emitted_next = emitted_next + zr;
                            room1 = (emitted_next < eff_len) ? eff_len - emitted_next : '0;
                            if (room1 != '0) begin
                                emitted_next        = emitted_next + 1'b1;
                                rsp.res_valid       = 1'b1;
                                rsp.zero_run        = zr;
                                rsp.has_coefficient = 1'b1;
                                rsp.coefficient     = sign_next ? (16'd0 - (code + 1'b1))
                                                                : (code + 1'b1);
                            end else if (zr != '0) begin
                                rsp.res_valid = 1'b1;
                                rsp.zero_run  = zr;
                            end
                        end else if (!mode) begin
                            if (code == '0) begin
                                kp_next = kp_add(kp_next, GR_UP);
                            end else begin
                                kp_next = kp_sub(kp_next, GR_DOWN);
                            end
                            if (room0 != '0) begin
                                emitted_next        = emitted_next + 1'b1;
                                rsp.res_valid       = 1'b1;
                                rsp.has_coefficient = 1'b1;
                                rsp.coefficient     = (code == '0) ? '0
                                                    : half_mag({1'b0, code});
                            end
                        end else begin
                            nbits     = bit_len(code);
                            code_next = code;
                            if (nbits != '0) begin
                                held_next  = nbits;
                                buf_next   = '0;
                                phase_next = PH_SPLIT;
                            end else begin
                                do_split = 1'b1;
                                v1       = '0;
                            end
                        end
                    end

                    // Split an RLGR3 code into two values
                    if (do_split) begin
                        v2 = {1'b0, code_next} - {1'b0, v1};
                        if (v1 != '0 && v2 != '0) begin
                            kp_next = kp_sub(kp_next, RL_DOWN);
                        end else if (v1 == '0 && v2 == '0) begin
                            kp_next = kp_add(kp_next, 8'(RL_DOWN));
                        end
                        if (room0 != '0) begin
                            emitted_next        = emitted_next + 1'b1;
                            rsp.res_valid       = 1'b1;
                            rsp.has_coefficient = 1'b1;
                            rsp.coefficient     = half_mag({1'b0, v1});
                        end
                        code_next  = half_mag(v2);
                        phase_next = PH_SPLIT2;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Hold decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            kp_reg       <= KP_RESET;
            krp_reg      <= KP_RESET;
            held_reg     <= '0;
            unary_reg    <= '0;
            usat_reg     <= '0;
            run_reg      <= '0;
            sign_reg     <= 1'b0;
            emitted_reg  <= '0;
            from_run_reg <= 1'b0;
            buf_reg      <= '0;
            code_reg     <= '0;
        end else begin
            phase_reg    <= phase_next;
            kp_reg       <= kp_next;
            krp_reg      <= krp_next;
            held_reg     <= held_next;
            unary_reg    <= unary_next;
            usat_reg     <= usat_next;
            run_reg      <= run_next;
            sign_reg     <= sign_next;
            emitted_reg  <= emitted_next;
            from_run_reg <= from_run_next;
            buf_reg      <= buf_next;
            code_reg     <= code_next;
        end
    end

endmodule

// ===== hw/rtl/rlgr_entropy_decoder.sv =====
// RLGR1/RLGR3 entropy decoder top level: byte intake, step sequencer, output register.
// A byte is taken while idle; the decode unit then walks its bits one per cycle while the
// result channel is free, and no new byte is taken until the byte is done. Each byte passes
//   through intake, 8 bit steps and a wrap-up step, plus a further step per RLGR3 second
//   value; a stalled result channel holds the steps, and a last byte adds a closing step.
// The rate is set by the bit-serial decode unit, which takes one stream bit per step.
// Reset (aresetn low, synchronous): mode RLGR1, length 4096, adaptation state k=kr=1.
`timescale 1ns / 1ps
module rlgr_entropy_decoder #(
    parameter int MAX_OUTPUT_LENGTH = rlgr_pkg::MAX_OUTPUT_LENGTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_last_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rlgr_pkg::LEN_W-1:0]         m_zero_run,
    output logic signed [rlgr_pkg::COEF_W-1:0] m_coefficient,
    output logic                               m_has_coefficient,
    output logic                               m_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [7:0]                         cfg_index,
    input  logic [rlgr_pkg::LEN_W-1:0]         cfg_data
);
    import rlgr_pkg::*;

    top_state_t               state_reg, state_next;
    logic [7:0]               byte_reg, byte_next;
    logic                     last_reg, last_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic                     mode_reg;
    logic [LEN_W-1:0]         len_reg;
    logic                     m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]         zr_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic                     has_reg;
    logic                     mlast_reg;
    logic                     out_free;
    step_req_t                req;
    step_rsp_t                rsp;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == TS_IDLE);
    assign cfg_ready = 1'b1;

    rlgr_core #(
        .MAX_OUTPUT_LENGTH(MAX_OUTPUT_LENGTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .mode    (mode_reg),
        .out_len (len_reg),
        .rsp     (rsp)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE: begin
                if (s_valid) state_next = TS_BITS;
            end
            TS_BITS: begin
                if (cnt_reg == 4'd8 && !rsp.pending) begin
                    state_next = last_reg ? TS_CLOSE : TS_IDLE;
                end
            end
            TS_CLOSE: begin
                if (out_free) state_next = TS_IDLE;
            end
            default: state_next = TS_IDLE;
        endcase
    end

    // Step requests to the decode unit
    always_comb begin
        req.cmd    = CMD_NONE;
        req.bit_in = byte_reg[7];
        case (state_reg)
            TS_BITS: begin
                if (out_free && (cnt_reg != 4'd8 || rsp.pending)) req.cmd = CMD_BIT;
            end
            TS_CLOSE: begin
                if (out_free) req.cmd = CMD_CLOSE;
            end
            default: begin
            end
        endcase
    end

    // Byte shifter and bit count
    always_comb begin
        byte_next = byte_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        if (s_valid && s_ready) begin
            byte_next = s_data_byte;
            last_next = s_last_byte;
            cnt_next  = '0;
        end else if (rsp.bit_done) begin
            byte_next = {byte_reg[6:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    assign m_valid_next = rsp.res_valid ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TS_IDLE;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            mode_reg    <= 1'b0;
            len_reg     <= OUT_LEN_RESET;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MODE) mode_reg <= cfg_data[0];
                else if (cfg_index == REG_OUT_LEN) len_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        if (rsp.res_valid) begin
            zr_reg    <= rsp.zero_run;
            coef_reg  <= rsp.coefficient;
            has_reg   <= rsp.has_coefficient;
            mlast_reg <= rsp.last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_zero_run        = zr_reg;
    assign m_coefficient     = coef_reg;
    assign m_has_coefficient = has_reg;
    assign m_last            = mlast_reg;

endmodule

// ===== hw/rtl/rlgr_checker.sv =====
// Port-level checker for the RLGR entropy decoder, bound to the top level.
`timescale 1ns / 1ps
module rlgr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_coefficient,
    input logic        m_has_coefficient,
    input logic        m_last
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coefficient))
        else $error("result dropped or changed while stalled");

    // Drop ready while a byte is being decoded
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new request taken during decode");

    // Closing result carries only zeros
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !m_has_coefficient && m_coefficient == 16'd0)
        else $error("closing result carries a coefficient");

    // Zero-only results have a zero coefficient
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_coefficient |-> m_coefficient == 16'd0)
        else $error("coefficient set without has_coefficient");

endmodule

bind rlgr_entropy_decoder rlgr_checker u_rlgr_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_coefficient     (m_coefficient),
    .m_has_coefficient (m_has_coefficient),
    .m_last            (m_last)
);

// ===== bench/rlgr_entropy_decoder_tb.sv =====
// Testbench for the RLGR1/RLGR3 entropy decoder: directed table, random streams, scoreboard.
`timescale 1ns / 1ps
module rlgr_entropy_decoder_tb;
    import rlgr_pkg::*;

    localparam int MAXLEN   = 4096;
    localparam int WD_LIMIT = 6000;
    localparam int SETTLE   = 40;

    typedef struct packed {
        logic [12:0] zr;
        logic [15:0] coef;
        logic        has;
        logic        lst;
    } coef_rec_t;

    // one row of the directed table: a register write or a stream byte
    typedef struct {
        bit          is_cfg;
        logic [7:0]  idx;
        logic [12:0] val;
        logic [7:0]  data;
        bit          lst;
        bit          typed;
        coef_rec_t   want;
    } stim_row_t;

    logic        aclk, aresetn;
    logic        s_valid, s_ready, s_last_byte;
    logic [7:0]  s_data_byte;
    logic        m_valid, m_ready, m_has_coefficient, m_last;
    logic [12:0] m_zero_run;
    logic signed [15:0] m_coefficient;
    logic        cfg_valid, cfg_ready;
    logic [7:0]  cfg_index;
    logic [12:0] cfg_data;

    rlgr_entropy_decoder dut (.*);

    // decoder state kept by the bench
    int unsigned mode_r, len_r;
    int unsigned k_p, kp_p, kr_p, krp_p, bits_v, held_v, unary_v, usat_v;
    int unsigned run_v, code_v, sign_v, emitted_v;
    phase_t      phase_v;
    bit          run_code_v;
    coef_rec_t   produced[$];
    coef_rec_t   expected_coefs[$];

    int errors, n_bytes, n_coefs, n_blocks;
    int snd_pct, rcv_pct, hold_cycles, quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_len();
        return (len_r > MAXLEN) ? MAXLEN : len_r;
    endfunction

    function automatic int unsigned room();
        return (emitted_v < eff_len()) ? eff_len() - emitted_v : 0;
    endfunction

    function automatic void put(int unsigned zr, int unsigned c, bit h, bit l);
        coef_rec_t r;
        r.zr = zr[12:0];
        r.coef = c[15:0];
        r.has = h;
        r.lst = l;
        produced.push_back(r);
    endfunction

    function automatic void raise_kp(int unsigned d);
        kp_p = kp_p + d;
        if (kp_p > KP_LIMIT) kp_p = KP_LIMIT;
        k_p = kp_p >> GR_SHIFT;
    endfunction

    function automatic void lower_kp(int unsigned d);
        kp_p = (kp_p > d) ? kp_p - d : 0;
        k_p = kp_p >> GR_SHIFT;
    endfunction

    function automatic void grow_run(int unsigned v);
        run_v = run_v + v;
        if (run_v > MAXLEN) run_v = MAXLEN;
    endfunction

    function automatic int unsigned unfold(int unsigned v);
        if (v & 1) return (0 - ((v + 1) >> 1)) & 16'hFFFF;
        return (v >> 1) & 16'hFFFF;
    endfunction

    function automatic void emit_coef(int unsigned mag);
        if (room() > 0) begin
            emitted_v++;
            put(0, mag, 1'b1, 1'b0);
        end
    endfunction

    function automatic void close_split(int unsigned v1);
        int unsigned v2;
        v2 = code_v - v1;
        if (v1 != 0 && v2 != 0) lower_kp(2 * GR_DOWN);
        else if (v1 == 0 && v2 == 0) raise_kp(2 * GR_UP);
        emit_coef(unfold(v1));
        emit_coef(unfold(v2));
        phase_v = PH_START;
    endfunction

    function automatic void close_rice(int unsigned rem);
        int unsigned code, mag, zr, rm, nb, c;
        code = (rem | (unary_v << kr_p)) & 16'hFFFF;
        if (usat_v == 0) krp_p = (krp_p > 2) ? krp_p - 2 : 0;
        else if (usat_v != 1) begin
            krp_p = krp_p + usat_v;
            if (krp_p > KP_LIMIT) krp_p = KP_LIMIT;
        end
        kr_p = krp_p >> GR_SHIFT;
        phase_v = PH_START;
        if (run_code_v) begin
            lower_kp(RL_DOWN);
            mag = sign_v ? (0 - (code + 1)) & 16'hFFFF : (code + 1) & 16'hFFFF;
            rm = room();
            zr = (run_v < rm) ? run_v : rm;
            emitted_v += zr;
            if (room() > 0) begin
                emitted_v++;
                put(zr, mag, 1'b1, 1'b0);
            end else if (zr > 0) begin
                put(zr, 0, 1'b0, 1'b0);
            end
        end else if (mode_r == 0) begin
            mag = 0;
            if (code == 0) raise_kp(GR_UP);
            else begin
                lower_kp(GR_DOWN);
                mag = unfold(code);
            end
            emit_coef(mag);
        end else begin
            nb = 0;
            c = code;
            while (c != 0) begin
                nb++;
                c >>= 1;
            end
            code_v = code;
            if (nb > 0) begin
                held_v = nb;
                bits_v = 0;
                phase_v = PH_SPLIT;
            end else begin
                close_split(0);
            end
        end
    endfunction

    function automatic void decode_bit(int unsigned b);
        if (phase_v == PH_START) begin
            if (room() == 0) begin
                phase_v = PH_FULL;
                return;
            end
            run_v = 0; unary_v = 0; usat_v = 0; bits_v = 0;
            held_v = 0; sign_v = 0; code_v = 0;
            run_code_v = (k_p != 0);
            phase_v = run_code_v ? PH_ZEROS : PH_ONES;
        end
        case (phase_v)
            PH_ZEROS: begin
                if (b == 0) begin
                    grow_run(1 << k_p);
                    raise_kp(RL_UP);
                end else if (k_p != 0) begin
                    held_v = k_p;
                    bits_v = 0;
                    phase_v = PH_RUNREM;
                end else begin
                    phase_v = PH_SIGN;
                end
            end
            PH_RUNREM: begin
                bits_v = (bits_v << 1) | b;
                held_v--;
                if (held_v == 0) begin
                    grow_run(bits_v);
                    phase_v = PH_SIGN;
                end
            end
            PH_SIGN: begin
                sign_v = b;
                phase_v = PH_ONES;
            end
            PH_ONES: begin
                if (b) begin
                    unary_v = (unary_v + 1) & 16'hFFFF;
                    if (usat_v < 255) usat_v++;
                end else if (kr_p != 0) begin
                    held_v = kr_p;
                    bits_v = 0;
                    phase_v = PH_RICE;
                end else begin
                    close_rice(0);
                end
            end
            PH_RICE: begin
                bits_v = ((bits_v << 1) | b) & 16'hFFFF;
                held_v--;
                if (held_v == 0) close_rice(bits_v);
            end
            PH_SPLIT: begin
                bits_v = ((bits_v << 1) | b) & 16'hFFFF;
                held_v--;
                if (held_v == 0) close_split(bits_v);
            end
            default: ;
        endcase
    endfunction

    function automatic void clear_decoder();
        k_p = 1; kp_p = KP_RESET; kr_p = 1; krp_p = KP_RESET;
        bits_v = 0; held_v = 0; phase_v = PH_START; unary_v = 0; usat_v = 0;
        run_v = 0; code_v = 0; sign_v = 0; emitted_v = 0; run_code_v = 1'b0;
    endfunction

    // decode one byte into the produced list
    function automatic void decode_byte(logic [7:0] d, bit lst);
        produced.delete();
        for (int i = 7; i >= 0; i--) decode_bit(d[i]);
        if (lst) begin
            put(room(), 0, 1'b0, 1'b1);
            clear_decoder();
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // receiver: stall at random or for a counted hold-off, check each result
    always @(posedge aclk) begin
        coef_rec_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_coefs++;
                if (expected_coefs.size() == 0) begin
                    report_mismatch("unexpected result", m_zero_run, -1);
                end else begin
                    w = expected_coefs.pop_front();
                    if (m_zero_run !== w.zr) report_mismatch("zero_run", m_zero_run, w.zr);
                    if (m_coefficient !== w.coef)
                        report_mismatch("coefficient", m_coefficient, $signed(w.coef));
                    if (m_has_coefficient !== w.has)
                        report_mismatch("has_coefficient", m_has_coefficient, w.has);
                    if (m_last !== w.lst) report_mismatch("last", m_last, w.lst);
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_pct);
            end
        end
    end

    // watchdog: cycles without any request moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic drain();
        while (expected_coefs.size() != 0) @(posedge aclk);
        // a byte that yields nothing may still be in the decode unit
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [12:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_MODE) mode_r = val[0];
        else if (idx == REG_OUT_LEN) len_r = val;
        cfg_valid <= 1'b0;
    endtask

    // offer one byte; typed rows replace the predicted results
    task automatic send_byte(logic [7:0] d, bit lst, bit typed, coef_rec_t want);
        while ($urandom_range(99) < snd_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= lst;
        do @(posedge aclk); while (!s_ready);
        decode_byte(d, lst);
        if (typed) expected_coefs.push_back(want);
        else foreach (produced[i]) expected_coefs.push_back(produced[i]);
        n_bytes++;
        if (lst) n_blocks++;
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 8'($urandom);
        if (r < 70) return 8'h00;
        if (r < 85) return 8'hFF;
        if (r < 92) return 8'hFF << $urandom_range(7);
        return 8'hFF >> $urandom_range(7);
    endfunction

    stim_row_t table_rows[$];
    coef_rec_t none_rec;

    function automatic void add_byte(logic [7:0] d, bit lst);
        stim_row_t r;
        r = '{0, 0, 0, d, lst, 0, '0};
        table_rows.push_back(r);
    endfunction

    function automatic void add_reg(logic [7:0] idx, logic [12:0] val);
        stim_row_t r;
        r = '{1, idx, val, 0, 0, 0, '0};
        table_rows.push_back(r);
    endfunction

    initial begin
        stim_row_t r;
        int unsigned lens[4];
        errors = 0; n_bytes = 0; n_coefs = 0; n_blocks = 0;
        snd_pct = 0; rcv_pct = 0; hold_cycles = 0; quiet_cycles = 0;
        none_rec = '0;
        aresetn = 1'b0;
        s_valid = 1'b0; s_data_byte = '0; s_last_byte = 1'b0;
        m_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        mode_r = 0; len_r = 4096;
        clear_decoder();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: a lone all-zero last byte after reset closes a full-length block
        r = '{0, 0, 0, 8'h00, 1, 1, '{13'd4096, 16'd0, 1'b0, 1'b1}};
        table_rows.push_back(r);
        add_byte(8'hFF, 0); add_byte(8'h80, 0); add_byte(8'h7F, 0);
        add_byte(8'h55, 0); add_byte(8'hAA, 1);
        add_reg(REG_OUT_LEN, 13'd1);
        add_byte(8'h3C, 0); add_byte(8'hFF, 0); add_byte(8'hC3, 1);
        add_reg(REG_OUT_LEN, 13'd0);
        r = '{0, 0, 0, 8'h12, 1, 1, '{13'd0, 16'd0, 1'b0, 1'b1}};
        table_rows.push_back(r);
        add_reg(REG_MODE, 13'd1);
        add_reg(REG_OUT_LEN, 13'h1FFF);
        add_byte(8'h00, 0); add_byte(8'h00, 0); add_byte(8'hFF, 0);
        add_byte(8'hFF, 0); add_byte(8'h35, 0); add_byte(8'h3C, 1);
        add_reg(REG_MODE, 13'd0);
        add_reg(REG_OUT_LEN, 13'd4096);
        foreach (table_rows[i]) begin
            if (table_rows[i].is_cfg) begin
                s_valid <= 1'b0;
                write_reg(table_rows[i].idx, table_rows[i].val);
            end else begin
                send_byte(table_rows[i].data, table_rows[i].lst, table_rows[i].typed,
                          table_rows[i].want);
            end
        end

        // random streams over four idling phases and several settings
        lens = '{4096, 24, 1, 300};
        for (int ph = 0; ph < 4; ph++) begin
            s_valid <= 1'b0;
            write_reg(REG_MODE, 13'(ph & 1));
            write_reg(REG_OUT_LEN, 13'(lens[ph]));
            case (ph)
                0: begin snd_pct = 0;  rcv_pct = 0;  end
                1: begin snd_pct = 73; rcv_pct = 0;  end
                2: begin snd_pct = 0;  rcv_pct = 73; end
                default: begin snd_pct = 24; rcv_pct = 24; end
            endcase
            for (int n = 0; n < 64; n++) begin
                // hold the receiver off while the sender keeps offering
                if (ph == 0 && n == 10) hold_cycles = 400;
                // pause the sender until everything has come back
                if (ph == 1 && n == 30) begin
                    s_valid <= 1'b0;
                    while (expected_coefs.size() != 0) @(posedge aclk);
                end
                // a run of ones to push the rice code past 16 bits
                if (ph == 3 && n >= 20 && n < 30)
                    send_byte(8'hFF, 1'b0, 1'b0, none_rec);
                else
                    send_byte(pick_byte(), (n == 63) || ($urandom_range(11) == 0),
                              1'b0, none_rec);
            end
        end

        s_valid <= 1'b0;
        drain();
        $display("covered %0d bytes in %0d blocks, %0d results checked", n_bytes, n_blocks,
                 n_coefs);
        $display("both modes, lengths 0/1/24/300/4096/overlong, stalls and hold-offs");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== rlgr_entropy_decoder.f =====
hw/rtl/rlgr_pkg.sv
hw/rtl/rlgr_core.sv
hw/rtl/rlgr_entropy_decoder.sv
hw/rtl/rlgr_checker.sv
bench/rlgr_entropy_decoder_tb.sv
